// File: rtl/vwr_pkg.sv
// Shared constants, types and arithmetic helpers for the vertex weld and remap block.
// Used by vwr_cell and vertex_weld_remap_top; no dependencies.
package vwr_pkg;

    // Store sizing.
    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int LANES        = 8;
    localparam int LANE_W       = $clog2(LANES);
    localparam int ROWS         = MAX_VERTICES / LANES;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int KEY_W        = 96;

    // Stream field widths.
    localparam int S_DATA_W = 144;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 72;

    // Configuration register indexes.
    localparam logic CFG_MERGE_ENABLE  = 1'b0;
    localparam logic CFG_INV_TOLERANCE = 1'b1;

    localparam logic [10:0] VIDX_NONE   = 11'h7FF;
    localparam logic [15:0] CORNER_NONE = 16'hFFFF;

    // First-match link handed from one search cell to the next.
    typedef struct packed {
        logic              found;
        logic [LANE_W-1:0] lane;
    } t_link;

    // Magnitude of a signed Q16.16 coordinate (most negative value maps to 2^31).
    function automatic logic [31:0] coord_mag(input logic [31:0] c);
        logic [31:0] m;
        m = c[31] ? (~c + 32'd1) : c;
        return m;
    endfunction

    // Round half away from zero and saturate to a signed 32-bit key.
    function automatic logic [31:0] quantize(input logic [63:0] prod, input logic neg);
        logic [63:0] sum;
        logic [31:0] r;
        sum = prod + 64'h0000_0000_8000_0000;
        r   = sum[63:32];
        if (neg) begin
            if (r > 32'h8000_0000) begin
                r = 32'h8000_0000;
            end
            return 32'd0 - r;
        end
        if (r > 32'h7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// File: rtl/vwr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module vwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/vwr_cell.sv
// One search cell: a bank of stored key triples and its compare, chained by first match.
// Depends on vwr_pkg and vwr_ram.
module vwr_cell (
    input  logic                         i_clk,
    input  logic [vwr_pkg::LANE_W-1:0]   i_lane,
    input  logic                         i_we,
    input  logic [vwr_pkg::LANE_W-1:0]   i_wlane,
    input  logic [vwr_pkg::ROW_W-1:0]    i_waddr,
    input  logic [vwr_pkg::ROW_W-1:0]    i_raddr,
    input  logic [vwr_pkg::ROW_W-1:0]    i_row,
    input  logic [vwr_pkg::CNT_W-1:0]    i_unique,
    input  logic [vwr_pkg::KEY_W-1:0]    i_key,
    input  vwr_pkg::t_link               i_link,
    output vwr_pkg::t_link               o_link
);

    logic [vwr_pkg::KEY_W-1:0] w_rkey;
    logic                      w_live;
    logic                      w_hit;

    // Key bank for entries whose index falls on this lane.
    vwr_ram #(
        .WIDTH(vwr_pkg::KEY_W),
        .DEPTH(vwr_pkg::ROWS)
    ) u_bank (
        .i_clk  (i_clk),
        .i_we   (i_we && (i_wlane == i_lane)),
        .i_waddr(i_waddr),
        .i_wdata(i_key),
        .i_raddr(i_raddr),
        .o_rdata(w_rkey)
    );

    // Only entries below the unique count belong to the current mesh.
    assign w_live = {1'b0, i_row, i_lane} < i_unique;
    assign w_hit  = w_live && (w_rkey == i_key);

    // An earlier lane keeps priority.
    always_comb begin
        o_link = i_link;
        if (!i_link.found && w_hit) begin
            o_link.found = 1'b1;
            o_link.lane  = i_lane;
        end
    end

endmodule

// File: rtl/vertex_weld_remap_top.sv
// Top level of the vertex weld and remap block: control sequencer, quantizer, remap store.
// Depends on vwr_pkg, vwr_ram and vwr_cell.
//
// Usage: requests enter on the s_axis channel; tuser bit 0 selects vertex (0) or
// triangle (1), tuser bit 1 starts a new mesh. One result per request leaves on
// m_axis. Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
// A welded vertex is quantized first (one shared 32x32 multiplier, three
// coordinates) and then searched for over the stored unique keys, eight keys per cycle
// in a row of eight cells. A disabled vertex, an overflowed vertex or a disabled
// triangle goes from accept straight to its result; a welded triangle reads its
// three corners in turn through the one read port of the remap store.
// One request is worked on at a time; the output register holds a finished result
// while the next request is taken, so a stalled receiver costs only the wait for
// the register to empty. Reset clears the counters and the output valid, and loads
// merge_enable = 1 and inv_tolerance = 1.0; key and remap stores need no clearing,
// as entries are only read once written in the current mesh.
module vertex_weld_remap_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  logic [vwr_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // mode, new_mesh
    input  logic [vwr_pkg::S_USER_W-1:0]  s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // vertex_index, was_merged, overflow, mapped_a, mapped_b, mapped_c, merge_total
    output logic [vwr_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUANT,
        S_SEARCH,
        S_TRI,
        S_DONE
    } t_state;

    t_state r_state;
    logic [1:0]  r_step;
    logic        r_en;
    logic [31:0] r_inv;
    logic [vwr_pkg::CNT_W-1:0] r_vs, r_us, r_mc;
    logic [31:0] r_cx, r_cy, r_cz;
    logic [15:0] r_ca, r_cb, r_cc;
    logic [2:0]  r_cvalid;
    logic [63:0] r_prod;
    logic        r_neg;
    logic [31:0] r_kx, r_ky, r_kz;
    logic [vwr_pkg::ROW_W:0]   r_row;
    logic [vwr_pkg::ROW_W-1:0] r_rowd;
    logic        r_pend;
    logic [10:0] r_vidx;
    logic        r_merged, r_ovf;
    logic [15:0] r_ma, r_mb, r_mc_c;
    logic        r_mv;
    logic [vwr_pkg::M_DATA_W-1:0] r_mdata;

    logic        w_acc;
    logic [vwr_pkg::CNT_W-1:0] w_vs, w_us, w_mc;
    logic [31:0] w_recip, w_csel;
    logic [vwr_pkg::KEY_W-1:0] w_key;
    vwr_pkg::t_link w_link [vwr_pkg::LANES+1];
    logic [vwr_pkg::ROW_W:0] w_rows;
    logic        w_kwe;
    logic        w_rwe;
    logic [vwr_pkg::IDX_W-1:0] w_rwaddr, w_rwdata, w_rraddr, w_rrdata;
    logic [15:0] w_corner;
    logic        w_cval;
    logic [vwr_pkg::IDX_W-1:0] w_hit;
    logic        w_found, w_miss;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // Counters as seen by an accepted request, after a new-mesh clear.
    assign w_vs = s_axis_tuser[1] ? '0 : r_vs;
    assign w_us = s_axis_tuser[1] ? '0 : r_us;
    assign w_mc = s_axis_tuser[1] ? '0 : r_mc;

    assign w_recip = (r_inv == 32'd0) ? 32'hFFFF_FFFF : r_inv;

    // Coordinate fed to the shared multiplier.
    always_comb begin
        case (r_step)
            2'd0:    w_csel = r_cx;
            2'd1:    w_csel = r_cy;
            default: w_csel = r_cz;
        endcase
    end

    // Corner read from the remap store.
    always_comb begin
        case (r_step)
            2'd0:    w_corner = r_ca;
            2'd1:    w_corner = r_cb;
            default: w_corner = r_cc;
        endcase
    end

    assign w_key = {r_kz, r_ky, r_kx};

    // Row of search cells.
    assign w_link[0] = '0;
    for (genvar g = 0; g < vwr_pkg::LANES; g++) begin : g_cell
        vwr_cell u_cell (
            .i_clk   (i_clk),
            .i_lane  (vwr_pkg::LANE_W'(g)),
            .i_we    (w_kwe),
            .i_wlane (r_us[vwr_pkg::LANE_W-1:0]),
            .i_waddr (r_us[vwr_pkg::IDX_W-1:vwr_pkg::LANE_W]),
            .i_raddr (r_row[vwr_pkg::ROW_W-1:0]),
            .i_row   (r_rowd),
            .i_unique(r_us),
            .i_key   (w_key),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    assign w_rows  = (vwr_pkg::ROW_W + 1)'((r_us + vwr_pkg::CNT_W'(vwr_pkg::LANES - 1))
                     >> vwr_pkg::LANE_W);
    assign w_found = (r_state == S_SEARCH) && r_pend && w_link[vwr_pkg::LANES].found;
    assign w_miss  = (r_state == S_SEARCH) && !w_found &&
                     ((r_us == '0) ||
                      (r_pend && ({1'b0, r_rowd} + 1'b1 >= w_rows)));
    assign w_hit   = w_found ? {r_rowd, w_link[vwr_pkg::LANES].lane}
                             : r_us[vwr_pkg::IDX_W-1:0];
    assign w_kwe   = w_miss;

    // Remap store writes: disabled vertex at accept, welded vertex at search end.
    always_comb begin
        w_rwe    = 1'b0;
        w_rwaddr = r_vs[vwr_pkg::IDX_W-1:0];
        w_rwdata = w_hit;
        if (w_acc && !s_axis_tuser[0] && !r_en &&
            (w_vs < vwr_pkg::CNT_W'(vwr_pkg::MAX_VERTICES))) begin
            w_rwe    = 1'b1;
            w_rwaddr = w_vs[vwr_pkg::IDX_W-1:0];
            w_rwdata = w_vs[vwr_pkg::IDX_W-1:0];
        end else if (w_found || w_miss) begin
            w_rwe = 1'b1;
        end
    end

    assign w_rraddr = w_corner[vwr_pkg::IDX_W-1:0];

    vwr_ram #(
        .WIDTH(vwr_pkg::IDX_W),
        .DEPTH(vwr_pkg::MAX_VERTICES)
    ) u_remap (
        .i_clk  (i_clk),
        .i_we   (w_rwe),
        .i_waddr(w_rwaddr),
        .i_wdata(w_rwdata),
        .i_raddr(w_rraddr),
        .o_rdata(w_rrdata)
    );

    assign w_cval = (r_step == 2'd1) ? r_cvalid[0] :
                    (r_step == 2'd2) ? r_cvalid[1] : r_cvalid[2];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b1;
            r_inv <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vwr_pkg::CFG_MERGE_ENABLE:  r_en  <= i_cfg_data[0];
                vwr_pkg::CFG_INV_TOLERANCE: r_inv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer with its registered results and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_vs    <= '0;
            r_us    <= '0;
            r_mc    <= '0;
            r_pend  <= 1'b0;
            r_row   <= '0;
            r_mv    <= 1'b0;
        end else begin
            if (r_mv && m_axis_tready && (r_state != S_DONE)) begin
                r_mv <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_cx     <= s_axis_tdata[31:0];
                        r_cy     <= s_axis_tdata[63:32];
                        r_cz     <= s_axis_tdata[95:64];
                        r_ca     <= s_axis_tdata[111:96];
                        r_cb     <= s_axis_tdata[127:112];
                        r_cc     <= s_axis_tdata[143:128];
                        r_cvalid <= {
                            !s_axis_tdata[143] && ({1'b0, s_axis_tdata[142:128]} <
                                {5'd0, w_vs}),
                            !s_axis_tdata[127] && ({1'b0, s_axis_tdata[126:112]} <
                                {5'd0, w_vs}),
                            !s_axis_tdata[111] && ({1'b0, s_axis_tdata[110:96]} <
                                {5'd0, w_vs})};
                        r_us     <= w_us;
                        r_mc     <= w_mc;
                        r_merged <= 1'b0;
                        r_step   <= '0;
                        if (!s_axis_tuser[0]) begin
                            r_ma   <= '0;
                            r_mb   <= '0;
                            r_mc_c <= '0;
                            if (w_vs >= vwr_pkg::CNT_W'(vwr_pkg::MAX_VERTICES)) begin
                                r_ovf   <= 1'b1;
                                r_vidx  <= vwr_pkg::VIDX_NONE;
                                r_vs    <= w_vs;
                                r_state <= S_DONE;
                            end else if (!r_en) begin
                                r_ovf   <= 1'b0;
                                r_vidx  <= w_vs;
                                r_vs    <= w_vs + 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_ovf   <= 1'b0;
                                r_vidx  <= vwr_pkg::VIDX_NONE;
                                r_vs    <= w_vs;
                                r_state <= S_QUANT;
                            end
                        end else begin
                            r_ovf  <= 1'b0;
                            r_vidx <= vwr_pkg::VIDX_NONE;
                            r_vs   <= w_vs;
                            if (!r_en) begin
                                r_ma    <= s_axis_tdata[111:96];
                                r_mb    <= s_axis_tdata[127:112];
                                r_mc_c  <= s_axis_tdata[143:128];
                                r_state <= S_DONE;
                            end else begin
                                r_ma    <= '0;
                                r_mb    <= '0;
                                r_mc_c  <= '0;
                                r_state <= S_TRI;
                            end
                        end
                    end
                end
                S_QUANT: begin
                    // Multiply one coordinate a cycle; round the previous product.
                    if (r_step != 2'd3) begin
                        r_prod <= 64'(vwr_pkg::coord_mag(w_csel)) * 64'(w_recip);
                        r_neg  <= w_csel[31];
                    end
                    case (r_step)
                        2'd1:    r_kx <= vwr_pkg::quantize(r_prod, r_neg);
                        2'd2:    r_ky <= vwr_pkg::quantize(r_prod, r_neg);
                        2'd3:    r_kz <= vwr_pkg::quantize(r_prod, r_neg);
                        default: ;
                    endcase
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_row   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // Issue one row a cycle; compare the row read the cycle before.
                    r_rowd <= r_row[vwr_pkg::ROW_W-1:0];
                    r_row  <= r_row + 1'b1;
                    r_pend <= 1'b1;
                    if (w_found) begin
                        r_merged <= 1'b1;
                        r_mc     <= r_mc + 1'b1;
                        r_vidx   <= {1'b0, w_hit};
                        r_vs     <= r_vs + 1'b1;
                        r_state  <= S_DONE;
                    end else if (w_miss) begin
                        r_us    <= r_us + 1'b1;
                        r_vidx  <= {1'b0, w_hit};
                        r_vs    <= r_vs + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_TRI: begin
                    // Read one corner a cycle; data returns the cycle after.
                    case (r_step)
                        2'd1: r_ma   <= w_cval ? {6'd0, w_rrdata} : vwr_pkg::CORNER_NONE;
                        2'd2: r_mb   <= w_cval ? {6'd0, w_rrdata} : vwr_pkg::CORNER_NONE;
                        2'd3: r_mc_c <= w_cval ? {6'd0, w_rrdata} : vwr_pkg::CORNER_NONE;
                        default: ;
                    endcase
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_mv || m_axis_tready) begin
                        r_mdata <= {r_mc, r_mc_c, r_mb, r_ma, r_ovf, r_merged, r_vidx};
                        r_mv    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_mdata;

    // The vertex count never passes the store size.
    a_vs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vs <= vwr_pkg::CNT_W'(vwr_pkg::MAX_VERTICES))
        else $error("vertex count beyond store size");

    // Unique keys never outnumber vertices seen.
    a_us_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_us <= r_vs)
        else $error("unique count exceeds vertex count");

    // Merges never outnumber vertices seen.
    a_mc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mc <= r_vs)
        else $error("merge count exceeds vertex count");

    // A finished result always reaches the output register.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_mv || m_axis_tready)) |=> m_axis_tvalid)
        else $error("result not presented");

endmodule
